/* hdl/dcrb_pkg.sv */
// Package for the DC-removal block buffer: sizes, command codes and item types.
// No dependencies; imported by every module of the block.
package dcrb_pkg;

  localparam int BLOCK_SAMPLES = 256;
  localparam int NUM_BLOCKS    = 4;
  localparam int IDX_W         = $clog2(BLOCK_SAMPLES);
  localparam int BLK_W         = $clog2(NUM_BLOCKS);
  localparam int CNT_W         = $clog2(NUM_BLOCKS + 1);
  localparam int ADDR_W        = BLK_W + IDX_W;

  localparam int RAW_W     = 12;
  localparam int PCM_W     = 16;
  localparam int DC_W      = 12;
  localparam int DC_SHIFT  = 10;                // divide by 1024
  localparam int ACC_W     = DC_W + DC_SHIFT;
  localparam int PCM_SHIFT = PCM_W - RAW_W;     // scale by 16
  localparam logic [DC_W-1:0] DC_START = 12'd2048;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_TAKE    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [RAW_W-1:0] raw_sample;
    logic [3:0]       sample_channel;
    logic [BLK_W-1:0] block_select;
    logic [IDX_W-1:0] word_position;
  } in_item_t;

  typedef struct packed {
    logic signed [PCM_W-1:0] pcm_value;
    logic [BLK_W-1:0]        block_number;
    logic [IDX_W-1:0]        fill_position;
    logic                    block_complete;
    logic                    sample_dropped;
    logic                    ready_valid;
  } out_item_t;

  // Work handed from the front to the back: store access plus result fields.
  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [ADDR_W-1:0] addr;
    out_item_t         res;
  } job_t;

endpackage

/* hdl/dcrb_front.sv */
// Front part: accepts items, runs the DC estimate, fill tracking and both block lists.
// Emits one job per item to the queue. Depends on dcrb_pkg.
module dcrb_front import dcrb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  in_item_t  item_i,
  output job_t      job_o
);

  logic [DC_W-1:0]  dc_q, dc_d;
  logic             fill_open_q, fill_open_d;
  logic [BLK_W-1:0] fill_block_q, fill_block_d;
  logic [IDX_W-1:0] fill_index_q, fill_index_d;

  logic [BLK_W-1:0] free_item_q [NUM_BLOCKS];
  logic [BLK_W-1:0] free_item_d [NUM_BLOCKS];
  logic [BLK_W-1:0] free_head_q, free_head_d;
  logic [CNT_W-1:0] free_cnt_q, free_cnt_d;
  logic [BLK_W-1:0] rdy_item_q [NUM_BLOCKS];
  logic [BLK_W-1:0] rdy_item_d [NUM_BLOCKS];
  logic [BLK_W-1:0] rdy_head_q, rdy_head_d;
  logic [CNT_W-1:0] rdy_cnt_q, rdy_cnt_d;

  logic [ACC_W-1:0] dc_acc;
  logic [DC_W-1:0]  dc_new;
  logic [RAW_W-1:0] diff;
  logic             ok;
  logic [BLK_W-1:0] blk;
  logic [IDX_W-1:0] idx;
  logic [BLK_W-1:0] taken;

  assign dc_acc = {dc_q, {DC_SHIFT{1'b0}}} - ACC_W'(dc_q) + ACC_W'(item_i.raw_sample);
  assign dc_new = dc_acc[ACC_W-1:DC_SHIFT];
  assign diff   = item_i.raw_sample - dc_new;

  always_comb begin
    dc_d         = dc_q;
    fill_open_d  = fill_open_q;
    fill_block_d = fill_block_q;
    fill_index_d = fill_index_q;
    free_item_d  = free_item_q;
    free_head_d  = free_head_q;
    free_cnt_d   = free_cnt_q;
    rdy_item_d   = rdy_item_q;
    rdy_head_d   = rdy_head_q;
    rdy_cnt_d    = rdy_cnt_q;
    job_o        = '0;
    ok           = 1'b0;
    blk          = fill_block_q;
    idx          = fill_index_q;
    taken        = rdy_item_q[rdy_head_q];
    unique case (item_i.cmd)
      CMD_SAMPLE: begin
        ok = (item_i.sample_channel == '0);
        if (ok && !fill_open_q) begin
          if (free_cnt_q != '0) begin
            blk         = free_item_q[free_head_q];
            idx         = '0;
            free_head_d = free_head_q + 1'b1;
            free_cnt_d  = free_cnt_q - 1'b1;
          end else begin
            ok = 1'b0;
          end
        end
        if (!ok) begin
          job_o.res.sample_dropped = 1'b1;
        end else begin
          dc_d                    = dc_new;
          job_o.wr                = 1'b1;
          job_o.addr              = {blk, idx};
          job_o.res.pcm_value     = {diff, {PCM_SHIFT{1'b0}}};
          job_o.res.block_number  = blk;
          job_o.res.fill_position = idx;
          fill_block_d            = blk;
          if (idx == IDX_W'(BLOCK_SAMPLES - 1)) begin
            job_o.res.block_complete = 1'b1;
            fill_open_d  = 1'b0;
            fill_index_d = '0;
            if (rdy_cnt_q != CNT_W'(NUM_BLOCKS)) begin
              rdy_item_d[rdy_head_q + BLK_W'(rdy_cnt_q)] = blk;
              rdy_cnt_d = rdy_cnt_q + 1'b1;
            end else if (free_cnt_d != CNT_W'(NUM_BLOCKS)) begin
              free_item_d[free_head_d + BLK_W'(free_cnt_d)] = blk;
              free_cnt_d = free_cnt_d + 1'b1;
            end
          end else begin
            fill_open_d  = 1'b1;
            fill_index_d = idx + 1'b1;
          end
        end
      end
      CMD_TAKE: begin
        if (rdy_cnt_q != '0) begin
          job_o.res.ready_valid  = 1'b1;
          job_o.res.block_number = taken;
          rdy_head_d = rdy_head_q + 1'b1;
          rdy_cnt_d  = rdy_cnt_q - 1'b1;
          if (free_cnt_q != CNT_W'(NUM_BLOCKS)) begin
            free_item_d[free_head_q + BLK_W'(free_cnt_q)] = taken;
            free_cnt_d = free_cnt_q + 1'b1;
          end
        end
      end
      CMD_READ: begin
        job_o.rd                = 1'b1;
        job_o.addr              = {item_i.block_select, item_i.word_position};
        job_o.res.block_number  = item_i.block_select;
        job_o.res.fill_position = item_i.word_position;
      end
      CMD_RESTART: begin
        dc_d = DC_START;
        for (int i = 0; i < NUM_BLOCKS; i++) begin
          free_item_d[i] = BLK_W'(i);
        end
        free_head_d = '0;
        free_cnt_d  = CNT_W'(NUM_BLOCKS);
        rdy_head_d  = '0;
        rdy_cnt_d   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q         <= DC_START;
      fill_open_q  <= 1'b0;
      fill_block_q <= '0;
      fill_index_q <= '0;
      free_head_q  <= '0;
      free_cnt_q   <= CNT_W'(NUM_BLOCKS);
      rdy_head_q   <= '0;
      rdy_cnt_q    <= '0;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        free_item_q[i] <= BLK_W'(i);
        rdy_item_q[i]  <= '0;
      end
    end else if (accept_i) begin
      dc_q         <= dc_d;
      fill_open_q  <= fill_open_d;
      fill_block_q <= fill_block_d;
      fill_index_q <= fill_index_d;
      free_item_q  <= free_item_d;
      free_head_q  <= free_head_d;
      free_cnt_q   <= free_cnt_d;
      rdy_item_q   <= rdy_item_d;
      rdy_head_q   <= rdy_head_d;
      rdy_cnt_q    <= rdy_cnt_d;
    end
  end

endmodule

/* hdl/dcrb_queue.sv */
// Short job queue between front and back parts.
// Depends on dcrb_pkg.
module dcrb_queue import dcrb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  job_t  job_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output job_t  job_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* hdl/dcrb_back.sv */
// Back part: sample store access and the result register.
// Depends on dcrb_pkg.
module dcrb_back import dcrb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      job_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t result_o
);

  logic [PCM_W-1:0] store_q [NUM_BLOCKS * BLOCK_SAMPLES];
  logic [PCM_W-1:0] rdata_q;
  out_item_t        res_q;
  logic             rd_q;
  logic             valid_q;

  assign job_pop_o = job_valid_i && (!valid_q || pop_i);
  assign empty_o   = !valid_q;

  always_comb begin
    result_o = res_q;
    if (rd_q) result_o.pcm_value = rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o && job_i.wr) begin
      store_q[job_i.addr] <= job_i.res.pcm_value;
    end
    if (job_pop_o && job_i.rd) begin
      rdata_q <= store_q[job_i.addr];
    end
    if (job_pop_o) begin
      res_q <= job_i.res;
      rd_q  <= job_i.rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (job_pop_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

/* hdl/audio_dc_removal_block_buffer_unit.sv */
// Top level of the DC-removal block buffer: front, job queue, back.
// Depends on dcrb_pkg, dcrb_front, dcrb_queue, dcrb_back.
//
//   channel  | handshake             | payload
//   input    | push / full           | in_item_i  (in_item_t)
//   result   | pop / empty           | out_item_o (out_item_t)
//
// One item per cycle sustained while results are popped; a taken item's job is written
// into the job queue by the accepting edge, and from there it moves into the result
// register together with the store read.
// The 1024-word store has at most one access per cycle in the back part.
// Reset is asynchronous and clears lists, estimate and queues; the store is not cleared.
// full rises only when the four-entry job queue backs up behind a stalled result.
module audio_dc_removal_block_buffer_unit import dcrb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic accept;
  job_t front_job;
  job_t back_job;
  logic job_valid;
  logic job_pop;

  assign accept = push && !full;

  dcrb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .job_o    (front_job)
  );

  dcrb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .job_o   (back_job)
  );

  dcrb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (back_job),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (out_item_o)
  );

endmodule

/* hdl/dcrb_checker.sv */
// Port-level checks for the DC-removal block buffer, bound to the top level.
// Depends on dcrb_pkg.
module dcrb_checker import dcrb_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input in_item_t  in_item_i,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  a_reset_idle: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty && !full)
    else $error("result or full seen after reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("waiting result changed");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(out_item_o.block_complete && out_item_o.sample_dropped) &&
               !(out_item_o.ready_valid &&
                 (out_item_o.block_complete || out_item_o.sample_dropped)))
    else $error("conflicting result flags");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.sample_dropped |->
      out_item_o.pcm_value == '0 && out_item_o.block_number == '0 &&
      out_item_o.fill_position == '0)
    else $error("dropped item carries data");

endmodule

bind audio_dc_removal_block_buffer_unit dcrb_checker u_dcrb_checker (.*);
